// ----- src/pkt_pkg.sv -----
// ----------------------------------------------------------------------------
// pkt_pkg
// Shared types and constants for the peer key table with aging.
// ----------------------------------------------------------------------------
package pkt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_WORDS     = 4;
  localparam int IO_KEY_WORDS  = 4;
  localparam int WORD_W        = 64;
  localparam int ADDR_W        = 48;
  localparam int TIME_W        = 32;
  localparam int OUT_SLOT_W    = 6;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W       = ADDR_W + TIME_W;
  localparam int KEY_BITS      = 2 * KEY_WORDS * WORD_W;
  localparam int IO_KEY_BITS   = 2 * IO_KEY_WORDS * WORD_W;
  localparam int IN_DATA_W     = ADDR_W + TIME_W + IO_KEY_BITS;
  localparam int RES_BITS      = OUT_SLOT_W + IO_KEY_BITS;
  localparam int OUT_DATA_W    = ((RES_BITS + 7) / 8) * 8;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_COMMIT,
    ST_KEYS,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic                   ok;
    logic [IO_KEY_BITS-1:0] keys;
    logic [OUT_SLOT_W-1:0]  slot;
  } result_t;

endpackage

// ----- src/pkt_ram.sv -----
// ----------------------------------------------------------------------------
// pkt_ram
// Simple dual-port synchronous RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module pkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pkt_engine.sv -----
// ----------------------------------------------------------------------------
// pkt_engine
// Command sequencer: scans the entry memory, commits the update and
// collects the result of one command.
// ----------------------------------------------------------------------------
module pkt_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pkt_pkg::TIME_W-1:0]       timeout,
  input  logic                             s_valid,
  output logic                             s_ready,
  input  pkt_pkg::req_t                    s_req,
  input  logic [pkt_pkg::IO_KEY_BITS-1:0]  s_keys,
  output logic                             res_valid,
  input  logic                             res_ready,
  output pkt_pkg::result_t                 res
);

  localparam int SW = pkt_pkg::SLOT_W;
  localparam int CW = pkt_pkg::CNT_W;
  localparam int WW = pkt_pkg::WORD_W;
  localparam int KW = pkt_pkg::KEY_WORDS;
  localparam int IW = pkt_pkg::IO_KEY_WORDS;

  pkt_pkg::state_e state, state_next;
  pkt_pkg::req_t   req;
  logic [pkt_pkg::IO_KEY_BITS-1:0] key_in;
  logic [pkt_pkg::TABLE_ENTRIES-1:0] valid_bits;
  logic [CW-1:0] hwc;
  logic [SW-1:0] idx;
  logic          match_found, free_found, live_found;
  logic [SW-1:0] match_slot, free_slot, live_slot;

  logic [pkt_pkg::ENTRY_W-1:0] entry_rdata;
  logic [pkt_pkg::KEY_BITS-1:0] key_rdata, key_wdata;
  logic [pkt_pkg::IO_KEY_BITS-1:0] key_out;
  logic [pkt_pkg::ADDR_W-1:0] e_addr;
  logic [pkt_pkg::TIME_W-1:0] e_last;
  logic live, hit, in_range, last_idx;
  logic add_hit, add_claim, entry_we, key_we;
  logic [SW-1:0] tgt;

  assign e_addr   = entry_rdata[pkt_pkg::ENTRY_W-1:pkt_pkg::TIME_W];
  assign e_last   = entry_rdata[pkt_pkg::TIME_W-1:0];
  assign live     = valid_bits[idx] &&
                    (({1'b0, e_last} + {1'b0, timeout}) >= {1'b0, req.now});
  assign in_range = CW'(idx) < hwc;
  assign hit      = in_range && valid_bits[idx] && (e_addr == req.addr) &&
                    ((req.cmd == pkt_pkg::CMD_REMOVE) || live);
  assign last_idx = (idx == SW'(pkt_pkg::TABLE_ENTRIES - 1));

  assign add_hit   = (req.cmd == pkt_pkg::CMD_ADD) && match_found;
  assign add_claim = (req.cmd == pkt_pkg::CMD_ADD) && !match_found && free_found;
  assign tgt       = match_found ? match_slot : free_slot;

  genvar w;
  generate
    for (w = 0; w < KW; w++) begin : g_kin
      if (w < IW) begin : g_on
        assign key_wdata[w*WW +: WW]      = key_in[w*WW +: WW];
        assign key_wdata[(KW+w)*WW +: WW] = key_in[(IW+w)*WW +: WW];
      end else begin : g_off
        assign key_wdata[w*WW +: WW]      = '0;
        assign key_wdata[(KW+w)*WW +: WW] = '0;
      end
    end
    for (w = 0; w < IW; w++) begin : g_kout
      if (w < KW) begin : g_on
        assign key_out[w*WW +: WW]      = key_rdata[w*WW +: WW];
        assign key_out[(IW+w)*WW +: WW] = key_rdata[(KW+w)*WW +: WW];
      end else begin : g_off
        assign key_out[w*WW +: WW]      = '0;
        assign key_out[(IW+w)*WW +: WW] = '0;
      end
    end
  endgenerate

  pkt_ram #(.WIDTH(pkt_pkg::ENTRY_W), .DEPTH(pkt_pkg::TABLE_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (tgt),
    .wdata ({req.addr, req.now}),
    .raddr (idx),
    .rdata (entry_rdata)
  );

  pkt_ram #(.WIDTH(pkt_pkg::KEY_BITS), .DEPTH(pkt_pkg::TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (tgt),
    .wdata (key_wdata),
    .raddr (match_slot),
    .rdata (key_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      pkt_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = (s_req.cmd == pkt_pkg::CMD_CLEAR) ? pkt_pkg::ST_COMMIT
                                                         : pkt_pkg::ST_READ;
        end
      end
      pkt_pkg::ST_READ:  state_next = pkt_pkg::ST_CHECK;
      pkt_pkg::ST_CHECK: state_next = last_idx ? pkt_pkg::ST_COMMIT : pkt_pkg::ST_READ;
      pkt_pkg::ST_COMMIT: begin
        state_next = ((req.cmd == pkt_pkg::CMD_FIND) && match_found) ? pkt_pkg::ST_KEYS
                                                                     : pkt_pkg::ST_DONE;
      end
      pkt_pkg::ST_KEYS: state_next = pkt_pkg::ST_DONE;
      pkt_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = pkt_pkg::ST_IDLE;
        end
      end
      default: state_next = pkt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready   = (state == pkt_pkg::ST_IDLE);
    res_valid = (state == pkt_pkg::ST_DONE);
    entry_we  = (state == pkt_pkg::ST_COMMIT) &&
                (add_hit || add_claim || ((req.cmd == pkt_pkg::CMD_FIND) && match_found));
    key_we    = (state == pkt_pkg::ST_COMMIT) && (add_hit || add_claim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pkt_pkg::ST_IDLE;
      valid_bits <= '0;
      hwc        <= '0;
    end else begin
      state <= state_next;
      case (state)
        pkt_pkg::ST_IDLE: begin
          if (s_valid) begin
            req         <= s_req;
            key_in      <= s_keys;
            idx         <= '0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            live_found  <= 1'b0;
            match_slot  <= '0;
            free_slot   <= '0;
            live_slot   <= '0;
          end
        end
        pkt_pkg::ST_CHECK: begin
          if (!match_found && hit) begin
            match_found <= 1'b1;
            match_slot  <= idx;
          end
          if (!free_found && !live) begin
            free_found <= 1'b1;
            free_slot  <= idx;
          end
          if (!match_found && !hit && live && in_range) begin
            live_found <= 1'b1;
            live_slot  <= idx;
          end
          if (!last_idx) begin
            idx <= idx + 1'b1;
          end
        end
        pkt_pkg::ST_COMMIT: begin
          res.ok   <= 1'b0;
          res.slot <= '0;
          res.keys <= '0;
          case (req.cmd)
            pkt_pkg::CMD_ADD: begin
              if (add_hit || add_claim) begin
                res.ok   <= 1'b1;
                res.slot <= pkt_pkg::OUT_SLOT_W'(tgt);
              end
              if (add_claim) begin
                valid_bits[free_slot] <= 1'b1;
                if ((CW'(free_slot) + 1'b1) > hwc) begin
                  hwc <= CW'(free_slot) + 1'b1;
                end
              end
            end
            pkt_pkg::CMD_REMOVE: begin
              if (match_found) begin
                res.ok <= 1'b1;
                valid_bits[match_slot] <= 1'b0;
                if ((CW'(match_slot) + 1'b1) == hwc) begin
                  hwc <= live_found ? (CW'(live_slot) + 1'b1) : '0;
                end
              end
            end
            pkt_pkg::CMD_FIND: begin
              if (match_found) begin
                res.ok   <= 1'b1;
                res.slot <= pkt_pkg::OUT_SLOT_W'(match_slot);
              end
            end
            pkt_pkg::CMD_CLEAR: begin
              res.ok     <= 1'b1;
              valid_bits <= '0;
              hwc        <= '0;
            end
            default: res.ok <= 1'b0;
          endcase
        end
        pkt_pkg::ST_KEYS: res.keys <= key_out;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/peer_key_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// peer_key_table_with_aging
// Peer address to send/receive key table with per-entry aging.
// ----------------------------------------------------------------------------
// One command is handled at a time. Add, remove and find walk every slot of
// the entry memory, each slot in a read state and then a compare state. After
// the walk comes a commit state, a key read state for a successful find, a
// state that hands the result to the output register once it can take it, and
// the idle state in which the next transaction is taken. A table reset skips
// the walk and goes from the idle state straight to the commit state.
// The next transaction is taken while the previous result still waits on the
// master side.
module peer_key_table_with_aging (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_wdata,     // entry_timeout
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // peer_address, now_time, send_key_w0..w3, recv_key_w0..w3
  input  logic [pkt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [1:0]                       s_axis_tuser,  // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // slot_index, out_send_w0..w3, out_recv_w0..w3, zero fill
  output logic [pkt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tuser   // ok
);

  logic [pkt_pkg::TIME_W-1:0] timeout;
  pkt_pkg::req_t    s_req;
  pkt_pkg::result_t res;
  logic res_valid, res_ready;

  assign s_req.cmd  = pkt_pkg::cmd_e'(s_axis_tuser);
  assign s_req.addr = s_axis_tdata[pkt_pkg::ADDR_W-1:0];
  assign s_req.now  = s_axis_tdata[pkt_pkg::ADDR_W +: pkt_pkg::TIME_W];
  assign res_ready  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= pkt_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  pkt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .timeout   (timeout),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_req     (s_req),
    .s_keys    (s_axis_tdata[pkt_pkg::IN_DATA_W-1:pkt_pkg::ADDR_W+pkt_pkg::TIME_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= pkt_pkg::OUT_DATA_W'({res.keys, res.slot});
      m_axis_tuser <= res.ok;
    end
  end

endmodule

// ----- src/pkt_checker.sv -----
// ----------------------------------------------------------------------------
// pkt_checker
// Port-level checks for the peer key table, bound to the top level.
// ----------------------------------------------------------------------------
module pkt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pkt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("transaction taken while a command is in progress");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[pkt_pkg::OUT_SLOT_W-1:0] == '0)
    else $error("nonzero slot on failed command");

  a_fail_keys: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[pkt_pkg::OUT_DATA_W-1:pkt_pkg::OUT_SLOT_W] == '0)
    else $error("nonzero keys on failed command");

endmodule

bind peer_key_table_with_aging pkt_checker u_pkt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
